// File: sv/token_bucket_rate_limiter_macros.svh
// Assertion macros shared by the token bucket rate limiter RTL.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH

// same-cycle implication, off during reset
`define TBRL_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TBRL_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: sv/tbrl_pkg.sv
// Package for the token bucket rate limiter: field widths, register reset values,
// command and register codes, state types. No dependencies.
`default_nettype none

package tbrl_pkg;

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 10;
    localparam int NOW_W     = 63;
    localparam int CAP_W     = 16;
    localparam int AMT_W     = 32;
    localparam int INT_W     = 48;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CAP_W-1:0] CAP_RST = 16'd10;
    localparam logic [AMT_W-1:0] AMT_RST = 32'd65536;
    localparam logic [INT_W-1:0] INT_RST = 48'd1000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK     = 2'd0,
        CMD_QUERY     = 2'd1,
        CMD_RESET_KEY = 2'd2,
        CMD_RESET_ALL = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_AMOUNT   = 2'd1,
        CFG_INTERVAL = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_REFILL,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

endpackage

`default_nettype wire

// File: sv/token_bucket_rate_limiter.sv
// Token bucket rate limiter top level: command sequencer, config registers,
// bucket table (tbrl_table) and serial refill unit (tbrl_muldiv). Uses tbrl_pkg.
//
// One command at a time: start is taken at a clock edge where busy is low, and the
// result word shows on o_allowed/o_tokens_left for exactly one cycle with o_valid
// high; the receiver cannot stall it. A check or query that refills waits on the
// refill unit: a shift-add multiply (one bit of the amount per cycle), then a
// restoring divide (one product bit per cycle). A check or query without refill
// steps through the read, evaluate and finish states; a key reset and a query of
// a missing key end after the evaluate state; a key beyond the table answers in
// the cycle after start. Reset-all runs a clearing pass over the table, one row
// per cycle, and answers when the pass ends; the same pass runs after reset, and
// busy stays high through it. Config writes are taken any time but belong to
// idle periods.
`default_nettype none

`include "token_bucket_rate_limiter_macros.svh"

module token_bucket_rate_limiter #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbrl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [tbrl_pkg::CMD_W-1:0]     i_command,
    input  logic [tbrl_pkg::KEY_W-1:0]     i_key_index,
    input  logic [tbrl_pkg::NOW_W-1:0]     i_now_us,
    output logic                           o_valid,
    output logic                           o_allowed,
    output logic [tbrl_pkg::CAP_W-1:0]     o_tokens_left
);

    import tbrl_pkg::*;

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int LW   = CAP_W + FRACTION_BITS;
    localparam int RW   = 1 + LW + NOW_W;
    localparam int CMPW = ((AW > KEY_W) ? AW : KEY_W) + 1;
    localparam logic [LW-1:0] FRAC_ONE = LW'(1) << FRACTION_BITS;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [NOW_W-1:0]  r_now, n_now;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [NOW_W-1:0]  r_last, n_last;
    logic [NOW_W-1:0]  r_elapsed, n_elapsed;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_clr_reply, n_clr_reply;
    logic              r_md_start, n_md_start;
    logic              r_out_valid, n_out_valid;
    logic              r_allowed, n_allowed;
    logic [CAP_W-1:0]  r_left, n_left;

    logic [CAP_W-1:0]  r_capacity;
    logic [AMT_W-1:0]  r_amount;
    logic [INT_W-1:0]  r_interval;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [RW-1:0]     mem_wdata;
    logic [RW-1:0]     mem_rdata;

    logic              rd_valid;
    logic [LW-1:0]     rd_lvl;
    logic [NOW_W-1:0]  rd_last;

    logic              md_done;
    logic [LW-1:0]     md_quot;
    logic              md_big;

    logic              key_oob;
    logic [LW-1:0]     cap_fix;
    logic [NOW_W:0]    diff;
    logic              refill_ok;
    logic [LW:0]       sum;
    logic [LW-1:0]     lvl_dec;

    logic              oob_take;
    logic              oob_reply;

    tbrl_table #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (RW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    tbrl_muldiv #(
        .QW (LW)
    ) u_muldiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_md_start),
        .i_elapsed (r_elapsed),
        .i_amount  (r_amount),
        .i_divisor (r_interval),
        .o_done    (md_done),
        .o_quot    (md_quot),
        .o_big     (md_big)
    );

    assign rd_valid  = mem_rdata[RW-1];
    assign rd_lvl    = mem_rdata[RW-2 -: LW];
    assign rd_last   = mem_rdata[NOW_W-1:0];

    assign key_oob   = CMPW'(i_key_index) >= CMPW'(TABLE_ENTRIES);
    assign cap_fix   = {r_capacity, {FRACTION_BITS{1'b0}}};
    assign diff      = {1'b0, r_now} - {1'b0, rd_last};
    assign refill_ok = (r_interval != '0) && !diff[NOW_W] && (diff[NOW_W-1:0] != '0);
    assign sum       = {1'b0, r_lvl} + {1'b0, md_quot};
    assign lvl_dec   = r_lvl - FRAC_ONE;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_now       = r_now;
        n_lvl       = r_lvl;
        n_last      = r_last;
        n_elapsed   = r_elapsed;
        n_clr       = r_clr;
        n_clr_reply = r_clr_reply;
        n_md_start  = 1'b0;
        n_out_valid = 1'b0;
        n_allowed   = 1'b0;
        n_left      = '0;
        mem_we      = 1'b0;
        mem_addr    = AW'(r_key);
        mem_wdata   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_addr = r_clr;
                mem_we   = 1'b1;
                if (r_clr == AW'(TABLE_ENTRIES - 1)) begin
                    n_out_valid = r_clr_reply;
                    n_clr_reply = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_cmd = t_cmd'(i_command);
                    n_key = i_key_index;
                    n_now = i_now_us;
                    if (t_cmd'(i_command) == CMD_RESET_ALL) begin
                        n_clr       = '0;
                        n_clr_reply = 1'b1;
                        n_state     = ST_CLEAR;
                    end else if (key_oob) begin
                        n_out_valid = 1'b1;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                unique case (r_cmd)
                    CMD_CHECK: begin
                        if (!rd_valid) begin
                            n_lvl   = cap_fix;
                            n_last  = r_now;
                            n_state = ST_FINISH;
                        end else begin
                            n_lvl  = rd_lvl;
                            n_last = rd_last;
                            if (refill_ok) begin
                                n_elapsed  = diff[NOW_W-1:0];
                                n_md_start = 1'b1;
                                n_state    = ST_REFILL;
                            end else begin
                                n_state = ST_FINISH;
                            end
                        end
                    end
                    CMD_QUERY: begin
                        if (!rd_valid) begin
                            n_out_valid = 1'b1;
                            n_state     = ST_IDLE;
                        end else begin
                            n_lvl  = rd_lvl;
                            n_last = rd_last;
                            if (refill_ok) begin
                                n_elapsed  = diff[NOW_W-1:0];
                                n_md_start = 1'b1;
                                n_state    = ST_REFILL;
                            end else begin
                                n_state = ST_FINISH;
                            end
                        end
                    end
                    CMD_RESET_KEY: begin
                        mem_we      = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                    CMD_RESET_ALL: begin
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end
                endcase
            end
            ST_REFILL: begin
                if (md_done) begin
                    if (md_big || (sum > {1'b0, cap_fix})) begin
                        n_lvl = cap_fix;
                    end else begin
                        n_lvl = sum[LW-1:0];
                    end
                    n_last  = r_now;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                mem_we      = 1'b1;
                mem_wdata   = {1'b1, r_lvl, r_last};
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
                if (r_cmd == CMD_CHECK) begin
                    if (r_lvl >= FRAC_ONE) begin
                        mem_wdata = {1'b1, lvl_dec, r_last};
                        n_allowed = 1'b1;
                    end
                end else begin
                    n_left = r_lvl[LW-1 -: CAP_W];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_clr_reply <= 1'b0;
            r_md_start  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= CAP_RST;
            r_amount    <= AMT_RST;
            r_interval  <= INT_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_reply <= n_clr_reply;
            r_md_start  <= n_md_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                    CFG_AMOUNT:   r_amount   <= i_cfg_data[AMT_W-1:0];
                    CFG_INTERVAL: r_interval <= i_cfg_data[INT_W-1:0];
                    default: begin
                        r_capacity <= r_capacity;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_now     <= n_now;
        r_lvl     <= n_lvl;
        r_last    <= n_last;
        r_elapsed <= n_elapsed;
        r_allowed <= n_allowed;
        r_left    <= n_left;
    end

    assign busy          = (r_state != ST_IDLE) || !i_rst_n;
    assign o_valid       = r_out_valid;
    assign o_allowed     = r_allowed;
    assign o_tokens_left = r_left;

    assign oob_take  = start && !busy && key_oob && (t_cmd'(i_command) != CMD_RESET_ALL);
    assign oob_reply = o_valid && !o_allowed && (o_tokens_left == '0);

    `TBRL_ASSERT_IMP(a_word_idle, r_out_valid, r_state == ST_IDLE, "result word outside idle")
    `TBRL_ASSERT_IMP(a_md_refill, r_md_start, r_state == ST_REFILL, "refill start out of place")
    `TBRL_ASSERT_IMP(a_allow_check, r_allowed, r_out_valid && (r_cmd == CMD_CHECK), "stray allow")
    `TBRL_ASSERT_NXT(a_oob_zero, oob_take, oob_reply, "out-of-range key not answered zero")

endmodule

`default_nettype wire

// File: sv/tbrl_table.sv
// Bucket table memory: one row per key (valid, level, last refill time).
// Single address, synchronous write, registered read. No dependencies.
`default_nettype none

module tbrl_table #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/tbrl_muldiv.sv
// Bit-serial floor(elapsed * amount / divisor): shift-add multiply, one amount bit
// per cycle, then restoring divide, one product bit per cycle. Uses tbrl_pkg.
`default_nettype none

`include "token_bucket_rate_limiter_macros.svh"

module tbrl_muldiv #(
    parameter int QW = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tbrl_pkg::NOW_W-1:0] i_elapsed,
    input  logic [tbrl_pkg::AMT_W-1:0] i_amount,
    input  logic [tbrl_pkg::INT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [QW-1:0]              o_quot,
    output logic                       o_big
);

    import tbrl_pkg::*;

    localparam int PW = NOW_W + AMT_W;
    localparam int CW = $clog2(PW);

    t_md_state       r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [PW-1:0]   r_prod, n_prod;
    logic [INT_W-1:0] r_rem, n_rem;
    logic [QW-1:0]   r_quot, n_quot;
    logic            r_big, n_big;
    logic            r_done, n_done;

    logic [NOW_W:0]  mul_sum;
    logic [INT_W:0]  div_trial;
    logic [INT_W:0]  div_diff;
    logic            div_ge;

    assign mul_sum   = {1'b0, r_prod[PW-1 -: NOW_W]}
                     + (r_prod[0] ? {1'b0, i_elapsed} : {(NOW_W+1){1'b0}});
    assign div_trial = {r_rem, r_prod[PW-1]};
    assign div_ge    = div_trial >= {1'b0, i_divisor};
    assign div_diff  = div_trial - {1'b0, i_divisor};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_big   = r_big;
        n_done  = 1'b0;
        unique case (r_state)
            MD_IDLE: begin
                if (i_start) begin
                    n_prod  = {{NOW_W{1'b0}}, i_amount};
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_quot  = '0;
                    n_big   = 1'b0;
                    n_state = MD_MUL;
                end
            end
            MD_MUL: begin
                n_prod = {mul_sum, r_prod[AMT_W-1:1]};
                if (r_cnt == CW'(AMT_W - 1)) begin
                    n_cnt   = '0;
                    n_state = MD_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            MD_DIV: begin
                n_rem  = div_ge ? div_diff[INT_W-1:0] : div_trial[INT_W-1:0];
                n_prod = {r_prod[PW-2:0], 1'b0};
                n_quot = {r_quot[QW-2:0], div_ge};
                n_big  = r_big | r_quot[QW-1];
                if (r_cnt == CW'(PW - 1)) begin
                    n_done  = 1'b1;
                    n_state = MD_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_big  <= n_big;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_big  = r_big;

    `TBRL_ASSERT_IMP(a_start_idle, i_start, r_state == MD_IDLE, "start while unit busy")
    `TBRL_ASSERT_IMP(a_done_idle, r_done, r_state == MD_IDLE, "done pulse outside idle")
    `TBRL_ASSERT_IMP(a_rem_below, r_state == MD_DIV, r_rem < i_divisor, "remainder not reduced")

endmodule

`default_nettype wire

// File: tb/tb_token_bucket_rate_limiter.sv
// Self-checking testbench for token_bucket_rate_limiter: directed and random commands,
// an in-order scoreboard with its own bucket table and refill arithmetic, and a watchdog.
// Depends on tbrl_pkg and the token_bucket_rate_limiter RTL.
`default_nettype none

module tb_token_bucket_rate_limiter;
    timeunit 1ns;
    timeprecision 1ps;

    import tbrl_pkg::*;

    localparam int          BUCKETS    = 1024;
    localparam int          QUIET_MAX  = 20000;
    localparam logic [63:0] ONE_TOKEN  = 64'h1_0000;
    localparam logic [62:0] LATEST_US  = {63{1'b1}};

    typedef struct packed {
        logic        allowed;
        logic [15:0] left;
    } t_verdict;

    class bucket_board;
        logic [CAP_W-1:0] capacity;
        logic [AMT_W-1:0] amount;
        logic [INT_W-1:0] interval;
        bit               live[BUCKETS];
        logic [63:0]      level[BUCKETS];
        logic [62:0]      stamp[BUCKETS];
        t_verdict         owed[$];
        int               errors;

        function new();
            capacity = CAP_RST;
            amount   = AMT_RST;
            interval = INT_RST;
            errors   = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_CAPACITY: capacity = data[CAP_W-1:0];
                CFG_AMOUNT:   amount   = data[AMT_W-1:0];
                CFG_INTERVAL: interval = data[INT_W-1:0];
                default: ;
            endcase
        endfunction

        function void refill_bucket(int k, logic [62:0] now);
            logic [63:0]  full;
            logic [63:0]  gain;
            logic [127:0] prod;
            logic [127:0] quot;
            full = {32'd0, capacity, 16'd0};
            if (interval == 0 || now <= stamp[k])
                return;
            prod = 128'(now - stamp[k]) * 128'(amount);
            quot = prod / 128'(interval);
            gain = quot[63:0];
            if (quot[127:64] != 0 || gain > full || level[k] > full - gain)
                level[k] = full;
            else
                level[k] = level[k] + gain;
            stamp[k] = now;
        endfunction

        function void note_request(t_cmd cmd, logic [KEY_W-1:0] key, logic [62:0] now);
            t_verdict    v;
            int          k;
            logic [63:0] whole;
            v = '0;
            k = int'(key);
            case (cmd)
                CMD_CHECK: begin
                    if (!live[k]) begin
                        live[k]  = 1'b1;
                        level[k] = {32'd0, capacity, 16'd0};
                        stamp[k] = now;
                    end
                    refill_bucket(k, now);
                    if (level[k] >= ONE_TOKEN) begin
                        level[k]  = level[k] - ONE_TOKEN;
                        v.allowed = 1'b1;
                    end
                end
                CMD_QUERY: begin
                    if (live[k]) begin
                        refill_bucket(k, now);
                        whole  = level[k] >> 16;
                        v.left = (whole > 64'hFFFF) ? 16'hFFFF : whole[15:0];
                    end
                end
                CMD_RESET_KEY: live[k] = 1'b0;
                CMD_RESET_ALL: foreach (live[i]) live[i] = 1'b0;
                default: ;
            endcase
            owed.push_back(v);
        endfunction

        function void check_reply(logic allowed, logic [CAP_W-1:0] left);
            t_verdict v;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result word, allowed %0d tokens_left %0d",
                         $time, allowed, left);
                errors++;
                return;
            end
            v = owed.pop_front();
            if (allowed !== v.allowed) begin
                $display("%0t: allowed mismatch, expected %0d, actual %0d",
                         $time, v.allowed, allowed);
                errors++;
            end
            if (left !== v.left) begin
                $display("%0t: tokens_left mismatch, expected %0d, actual %0d",
                         $time, v.left, left);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_command;
    logic [KEY_W-1:0]     i_key_index;
    logic [NOW_W-1:0]     i_now_us;
    logic                 o_valid;
    logic                 o_allowed;
    logic [CAP_W-1:0]     o_tokens_left;

    bucket_board sb;
    logic [62:0] clock_us;
    logic [63:0] pace;
    int          quiet = 0;

    logic [CAP_W-1:0] cap_set[8];
    logic [AMT_W-1:0] amt_set[8];
    logic [INT_W-1:0] int_set[8];

    token_bucket_rate_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_key_index   (i_key_index),
        .i_now_us      (i_now_us),
        .o_valid       (o_valid),
        .o_allowed     (o_allowed),
        .o_tokens_left (o_tokens_left)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_reply(o_allowed, o_tokens_left);
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || o_valid === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_word(t_cmd cmd, logic [KEY_W-1:0] key, logic [62:0] now);
        start       <= 1'b1;
        i_command   <= cmd;
        i_key_index <= key;
        i_now_us    <= now;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(cmd, key, now);
    endtask

    task automatic random_word();
        int          r;
        t_cmd        cmd;
        logic [KEY_W-1:0] key;
        logic [63:0] wide;
        r = $urandom_range(0, 99);
        if (r < 60)
            cmd = CMD_CHECK;
        else if (r < 85)
            cmd = CMD_QUERY;
        else if (r < 97)
            cmd = CMD_RESET_KEY;
        else
            cmd = CMD_RESET_ALL;
        key  = ($urandom_range(0, 3) != 0) ? KEY_W'($urandom_range(0, 7))
                                           : KEY_W'($urandom_range(0, BUCKETS - 1));
        wide = {$urandom, $urandom};
        r    = $urandom_range(0, 99);
        if (r < 80)
            clock_us = clock_us + 63'(wide % (pace + 1));
        else if (r < 95 && r >= 88)
            clock_us = clock_us - 63'(wide % (pace + 1));
        else if (r >= 95)
            clock_us = wide[62:0];
        send_word(cmd, key, clock_us);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic settle();
        while (sb.pending() != 0 || busy !== 1'b0)
            @(posedge i_clk);
    endtask

    initial begin
        int left_in_phase;
        int burst;
        int gap;
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        start       = 1'b0;
        i_command   = '0;
        i_key_index = '0;
        i_now_us    = '0;
        clock_us    = '0;

        cap_set = '{16'd10, 16'hFFFF, 16'd3, 16'd0, 16'd20, 16'd50, 16'd7,
                    16'($urandom_range(1, 40))};
        amt_set = '{32'h1_0000, 32'hFFFF_FFFF, 32'h8000, 32'h1_0000, 32'd0,
                    32'h1_2345, $urandom, $urandom};
        int_set = '{48'd1000, 48'd1, 48'd100, 48'd10, 48'd50, 48'd0,
                    {48{1'b1}}, 48'($urandom_range(1, 5000))};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settle();

        // missing bucket, creation, both time extremes, key and global clear
        send_word(CMD_QUERY, 10'd0, 63'd0);
        send_word(CMD_CHECK, 10'd0, 63'd0);
        send_word(CMD_QUERY, 10'd0, 63'd0);
        send_word(CMD_CHECK, 10'd1023, LATEST_US);
        send_word(CMD_CHECK, 10'd1023, 63'd0);
        send_word(CMD_QUERY, 10'd1023, 63'd5);
        send_word(CMD_RESET_KEY, 10'd1023, 63'd5);
        send_word(CMD_QUERY, 10'd1023, 63'd5);
        send_word(CMD_RESET_ALL, 10'd0, 63'd5);
        send_word(CMD_QUERY, 10'd0, 63'd5);
        // drain one bucket past empty, then refill it
        for (int i = 0; i < 11; i++)
            send_word(CMD_CHECK, 10'd5, 63'd100);
        send_word(CMD_QUERY, 10'd5, 63'd2_500_100);
        send_word(CMD_QUERY, 10'd5, 63'd2_500_100);
        start <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            settle();
            write_reg(CFG_CAPACITY, CFG_W'(cap_set[p]));
            write_reg(CFG_AMOUNT, CFG_W'(amt_set[p]));
            write_reg(CFG_INTERVAL, CFG_W'(int_set[p]));
            i_cfg_we <= 1'b0;
            if (int_set[p] == 0)
                pace = 64'd1000;
            else if (int_set[p] > 48'h100_0000_0000)
                pace = 64'h100_0000_0000;
            else
                pace = 64'(int_set[p]);

            left_in_phase = 190;
            while (left_in_phase > 0) begin
                burst = $urandom_range(1, 24);
                if (burst > left_in_phase)
                    burst = left_in_phase;
                for (int b = 0; b < burst; b++)
                    random_word();
                left_in_phase -= burst;
                case ($urandom_range(0, 2))
                    0: gap = 0;
                    1: gap = $urandom_range(1, 8);
                    default: gap = $urandom_range(1, 160);
                endcase
                if (left_in_phase == 0 || gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/tbrl_pkg.sv
sv/tbrl_table.sv
sv/tbrl_muldiv.sv
sv/token_bucket_rate_limiter.sv
tb/tb_token_bucket_rate_limiter.sv
